### rtl/core/vltg_pkg.sv
// ----------------------------------------------------------------------------
// vltg_pkg - shared types and constants of the video line timing generator
// Holds the register index codes, timing constants and the structs that carry
// timing state, configuration and line results between the core modules.
// ----------------------------------------------------------------------------
package vltg_pkg;

    // leap step runs 0 .. LEAP_STEPS-1
    localparam logic [2:0]  LEAP_STEPS    = 3'd5;
    // line duration reported while the interface is off
    localparam logic [12:0] IDLE_DURATION = 13'h800;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HALF_LINES_PER_FIELD = 3'd0,
        REG_VIDEO_START_LINE     = 3'd1,
        REG_INTERRUPT_HALF_LINE  = 3'd2,
        REG_QUARTER_LINE_LENGTH  = 3'd3,
        REG_LEAP_LENGTH_A        = 3'd4,
        REG_LEAP_LENGTH_B        = 3'd5,
        REG_LEAP_PATTERN_BITS    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [9:0]  half_lines_per_field;
        logic [9:0]  video_start_line;
        logic [9:0]  interrupt_half_line;
        logic [11:0] quarter_line_length;
        logic [11:0] leap_length_a;
        logic [11:0] leap_length_b;
        logic [4:0]  leap_pattern_bits;
    } timing_cfg_t;

    typedef struct packed {
        logic [9:0] line_counter;
        logic       field_bit;
        logic [2:0] leap_step;
    } timing_state_t;

    typedef struct packed {
        logic [12:0] line_duration;
        logic        line_interrupt;
        logic        frame_start;
        logic        field_flag;
        logic [9:0]  line_number;
    } line_result_t;

endpackage

### rtl/core/vltg_line_step.sv
// ----------------------------------------------------------------------------
// vltg_line_step - one scan line of timing
// Works out the next counter state and the line result from the current state,
// the configuration and the active flag of the incoming word.
// ----------------------------------------------------------------------------
module vltg_line_step
    import vltg_pkg::*;
(
    input  timing_cfg_t   cfg,
    input  timing_state_t state_cur,
    input  logic          video_active,
    output timing_state_t state_nxt,
    output line_result_t  result
);

    logic [9:0]  line_inc;
    logic        wrap;
    logic [2:0]  leap_inc;
    logic [10:0] half_line;
    logic [11:0] half_line_inc;
    logic        leap_sel;
    logic        irq;

    always_comb begin
        line_inc = state_cur.line_counter + 10'd1;
        // end of field when the half-line position passes the field length
        wrap = {line_inc, state_cur.field_bit} >= ({1'b0, cfg.half_lines_per_field} + 11'd1);
        leap_inc = state_cur.leap_step + 3'd1;

        state_nxt = state_cur;
        if (!video_active) begin
            state_nxt.line_counter = '0;
        end else if (wrap) begin
            state_nxt.line_counter = '0;
            if (!cfg.half_lines_per_field[0]) begin
                state_nxt.field_bit = ~state_cur.field_bit;
            end
            state_nxt.leap_step = (leap_inc == LEAP_STEPS) ? 3'd0 : leap_inc;
        end else begin
            state_nxt.line_counter = line_inc;
        end

        half_line     = {state_nxt.line_counter, state_nxt.field_bit};
        half_line_inc = {1'b0, half_line} + 12'd1;

        // progressive timing or odd coincidence: compare whole lines
        if (cfg.half_lines_per_field[0] || cfg.interrupt_half_line[0]) begin
            irq = state_nxt.line_counter == {1'b0, cfg.interrupt_half_line[9:1]};
        end else begin
            irq = (!state_nxt.field_bit && half_line == {1'b0, cfg.interrupt_half_line})
               || (state_nxt.field_bit && half_line_inc == {2'b0, cfg.interrupt_half_line})
               || (!state_nxt.field_bit && half_line == {1'b0, cfg.half_lines_per_field}
                   && cfg.interrupt_half_line == 10'd0);
        end

        leap_sel = (state_nxt.leap_step < LEAP_STEPS)
                 ? cfg.leap_pattern_bits[state_nxt.leap_step] : 1'b0;

        if (!video_active) begin
            result.line_number    = '0;
            result.field_flag     = state_cur.field_bit;
            result.frame_start    = 1'b0;
            result.line_interrupt = 1'b0;
            result.line_duration  = IDLE_DURATION;
        end else begin
            result.line_number    = state_nxt.line_counter;
            result.field_flag     = state_nxt.field_bit;
            result.frame_start    = state_nxt.line_counter
                                    == {1'b0, cfg.video_start_line[9:1]};
            result.line_interrupt = irq;
            if (state_nxt.line_counter == 10'd1) begin
                result.line_duration = {1'b0, leap_sel ? cfg.leap_length_b : cfg.leap_length_a};
            end else begin
                result.line_duration = {1'b0, cfg.quarter_line_length} + 13'd1;
            end
        end
    end

endmodule

### rtl/core/video_line_timing_generator.sv
// ----------------------------------------------------------------------------
// video_line_timing_generator - scan line timing for the video interface
// the result word is registered and shows on m_ in the cycle after its input word is accepted
// throughput: one line word per cycle while m_tready is high, limited only by the single result stage
// the line, field and leap counters update in the accept cycle, so the next
// word can follow straight away
// reset: synchronous active low aresetn clears counters, config and m_tvalid
// ----------------------------------------------------------------------------
module video_line_timing_generator
    import vltg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // configuration write port, no read-back
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    // line request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // [0] video_active, [7:1] zero

    // line result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata   // [9:0] line_number, [10] field_flag,
                                             // [11] frame_start, [12] line_interrupt,
                                             // [25:13] line_duration, [31:26] zero
);

    timing_cfg_t   cfg_reg;
    timing_state_t state_reg;
    timing_state_t state_next;
    line_result_t  result_reg;
    line_result_t  result_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic          s_accept;

    // ------------------------------------------------------------------
    // configuration registers, writes beyond the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_HALF_LINES_PER_FIELD: cfg_reg.half_lines_per_field <= cfg_wdata[9:0];
                REG_VIDEO_START_LINE:     cfg_reg.video_start_line     <= cfg_wdata[9:0];
                REG_INTERRUPT_HALF_LINE:  cfg_reg.interrupt_half_line  <= cfg_wdata[9:0];
                REG_QUARTER_LINE_LENGTH:  cfg_reg.quarter_line_length  <= cfg_wdata;
                REG_LEAP_LENGTH_A:        cfg_reg.leap_length_a        <= cfg_wdata;
                REG_LEAP_LENGTH_B:        cfg_reg.leap_length_b        <= cfg_wdata;
                REG_LEAP_PATTERN_BITS:    cfg_reg.leap_pattern_bits    <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: a new word goes in whenever the result stage is empty
    // or is being drained in this cycle
    // ------------------------------------------------------------------
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // next line state and result for the word on s_tdata
    vltg_line_step u_line_step (
        .cfg          (cfg_reg),
        .state_cur    (state_reg),
        .video_active (s_tdata[0]),
        .state_nxt    (state_next),
        .result       (result_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // timing counters advance only on an accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                state_reg <= state_next;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, result_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_leap_range : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.leap_step < LEAP_STEPS)
        else $error("leap step left its range");

    a_idle_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tdata[0]) |=> (state_reg.line_counter == 10'd0
                                       && result_reg.line_duration == IDLE_DURATION))
        else $error("inactive line did not clear the counter");

    a_accept_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted word produced no result");

    a_field_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !s_accept) |=> $stable(state_reg))
        else $error("timing state moved without an accepted word");

endmodule

### bench/tb_video_line_timing_generator.sv
// ----------------------------------------------------------------------------
// tb_video_line_timing_generator - self-checking bench for the line timer
// Drives line request words with bursty valid and checks each result word
// against a cycle-free line predictor kept in step with the register writes.
// A short directed table covers reset, extreme and special settings, then
// random phases reload the timing registers and run long line sequences.
// ----------------------------------------------------------------------------
module tb_video_line_timing_generator;
    import vltg_pkg::*;

    // write to an index that has no register behind it, must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int DIRECTED_ROWS = 25;

    // one directed row: settings to use, the line request and an optional
    // expectation typed in by hand
    typedef struct packed {
        logic [1:0]   cfg_sel;
        logic         active;
        logic         typed;
        line_result_t want;
    } line_row_t;

    // what the sender knows about a word it has put on the bus
    typedef struct packed {
        logic         typed;
        line_result_t want;
    } line_note_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;   // [0] video_active, [7:1] zero
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;        // [9:0] line_number, [10] field_flag,
                                            // [11] frame_start, [12] line_interrupt,
                                            // [25:13] line_duration

    // predictor copy of the timing registers and counters
    timing_cfg_t pred_cfg;
    logic [9:0]  pred_line;
    logic        pred_field;
    logic [2:0]  pred_leap;

    line_result_t line_expect [$];
    line_note_t   line_notes [$];
    int           errors = 0;

    // sender burst shaping
    int burst_left = 0;
    int gap_max = 0;

    timing_cfg_t timing_sets [4];
    line_row_t   directed_rows [DIRECTED_ROWS];

    video_line_timing_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // generous ceiling, far beyond the slowest legal run
    initial begin
        #(4 * 500_000);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // line predictor: advances the counters by one line and returns the word
    // the block should give for it
    // ------------------------------------------------------------------------
    function automatic line_result_t advance_line(input logic active);
        line_result_t r;
        logic [10:0]  half_pos;
        logic         pick_b;
        r = '0;
        if (!active) begin
            // interface off: counter cleared, field and leap step held
            pred_line = '0;
            r.field_flag = pred_field;
            r.line_duration = IDLE_DURATION;
            return r;
        end

        pred_line = pred_line + 10'd1;
        // end of field once the half line position passes the field length
        if ({pred_line, pred_field} >= {1'b0, pred_cfg.half_lines_per_field} + 11'd1) begin
            pred_line = '0;
            if (!pred_cfg.half_lines_per_field[0])
                pred_field = ~pred_field;
            pred_leap = pred_leap + 3'd1;
            if (pred_leap == LEAP_STEPS)
                pred_leap = '0;
        end

        r.line_number = pred_line;
        r.field_flag  = pred_field;
        r.frame_start = (pred_line == pred_cfg.video_start_line[9:1]);

        if (pred_cfg.half_lines_per_field[0] || pred_cfg.interrupt_half_line[0]) begin
            // progressive, or interlaced with an odd coincidence line
            r.line_interrupt = (pred_line == pred_cfg.interrupt_half_line[9:1]);
        end else begin
            // interlaced, even coincidence: compare in half lines per field
            half_pos = {pred_line, pred_field};
            r.line_interrupt =
                (!pred_field && half_pos == {1'b0, pred_cfg.interrupt_half_line}) ||
                (pred_field && half_pos + 11'd1 == {1'b0, pred_cfg.interrupt_half_line}) ||
                (!pred_field && half_pos == {1'b0, pred_cfg.half_lines_per_field} &&
                 pred_cfg.interrupt_half_line == 10'd0);
        end

        if (pred_line == 10'd1) begin
            // leap line: pattern bit of the current leap step picks the length
            pick_b = (pred_leap < LEAP_STEPS) ? pred_cfg.leap_pattern_bits[pred_leap] : 1'b0;
            r.line_duration = pick_b ? {1'b0, pred_cfg.leap_length_b}
                                     : {1'b0, pred_cfg.leap_length_a};
        end else begin
            r.line_duration = {1'b0, pred_cfg.quarter_line_length} + 13'd1;
        end
        return r;
    endfunction

    function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_HALF_LINES_PER_FIELD: pred_cfg.half_lines_per_field = val[9:0];
            REG_VIDEO_START_LINE:     pred_cfg.video_start_line     = val[9:0];
            REG_INTERRUPT_HALF_LINE:  pred_cfg.interrupt_half_line  = val[9:0];
            REG_QUARTER_LINE_LENGTH:  pred_cfg.quarter_line_length  = val;
            REG_LEAP_LENGTH_A:        pred_cfg.leap_length_a        = val;
            REG_LEAP_LENGTH_B:        pred_cfg.leap_length_b        = val;
            REG_LEAP_PATTERN_BITS:    pred_cfg.leap_pattern_bits    = val[4:0];
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // bus monitor: register writes, accepted line words and result words all
    // sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        line_result_t got;
        line_result_t want;
        line_note_t   note;
        if (!aresetn) begin
            pred_cfg   = '0;
            pred_line  = '0;
            pred_field = 1'b0;
            pred_leap  = '0;
        end else begin
            if (cfg_wr_en)
                apply_write(cfg_index, cfg_wdata);

            // oldest expectation first, then the word taken this edge
            if (m_tvalid && m_tready) begin
                got = line_result_t'(m_tdata[25:0]);
                if (line_expect.size() == 0) begin
                    errors++;
                    $display("%0t: result word %h with nothing expected", $time, m_tdata);
                end else begin
                    want = line_expect.pop_front();
                    check_field("line_number", want.line_number, got.line_number);
                    check_field("field_flag", want.field_flag, got.field_flag);
                    check_field("frame_start", want.frame_start, got.frame_start);
                    check_field("line_interrupt", want.line_interrupt, got.line_interrupt);
                    check_field("line_duration", want.line_duration, got.line_duration);
                end
            end

            if (s_tvalid && s_tready) begin
                note = line_notes.pop_front();
                want = advance_line(s_tdata[0]);
                line_expect.push_back(note.typed ? note.want : want);
            end
        end
    end

    // receiver: changes its stall pattern every so often
    always @(negedge aclk) begin : receiver
        int stall_mode;
        int stall_left;
        int stall_tick;
        if (stall_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(32, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: m_tready <= 1'b1;                          // no back-pressure
            1: m_tready <= ($urandom_range(0, 3) != 0);   // light random stalls
            default: m_tready <= (stall_tick % 8 == 0);   // one slot in eight
        endcase
    end

    // ------------------------------------------------------------------------
    // sender side, all driven on the falling edge
    // ------------------------------------------------------------------------
    task automatic send_line(input logic active, input logic typed, input line_result_t want);
        line_note_t n;
        if (gap_max != 0 && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        n.typed = typed;
        n.want  = want;
        line_notes.push_back(n);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, active};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // hold off until every word in flight has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (line_expect.size() != 0 || line_notes.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
    endtask

    task automatic load_timing(input timing_cfg_t c, input logic poke_unused);
        write_reg(REG_HALF_LINES_PER_FIELD, {2'b0, c.half_lines_per_field});
        write_reg(REG_VIDEO_START_LINE, {2'b0, c.video_start_line});
        write_reg(REG_INTERRUPT_HALF_LINE, {2'b0, c.interrupt_half_line});
        write_reg(REG_QUARTER_LINE_LENGTH, c.quarter_line_length);
        write_reg(REG_LEAP_LENGTH_A, c.leap_length_a);
        write_reg(REG_LEAP_LENGTH_B, c.leap_length_b);
        write_reg(REG_LEAP_PATTERN_BITS, {7'b0, c.leap_pattern_bits});
        // zeros to the spare index after the real values would show a decode slip
        if (poke_unused)
            write_reg(REG_UNUSED, '0);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic line_row_t line_row(input int sel, input bit active, input bit typed,
                                           input int line_no, input bit fld, input bit frm,
                                           input bit irq, input int dur);
        line_row_t r;
        r.cfg_sel              = sel[1:0];
        r.active               = active;
        r.typed                = typed;
        r.want.line_number     = line_no[9:0];
        r.want.field_flag      = fld;
        r.want.frame_start     = frm;
        r.want.line_interrupt  = irq;
        r.want.line_duration   = dur[12:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          cur_sel;
        int          n_lines;
        int          idle_odds;
        int          hl;
        bit          bulk;
        logic        active;
        timing_cfg_t rnd;

        // 0: register reset values
        timing_sets[0] = '0;
        // 1: every register but leap length a at its top value, progressive
        timing_sets[1] = '{10'd1023, 10'd1023, 10'd1023, 12'd4095, 12'd0, 12'd4095, 5'b11111};
        // 2: short interlaced field, odd coincidence line
        timing_sets[2] = '{10'd10, 10'd4, 10'd5, 12'd99, 12'd7, 12'd9, 5'b01010};
        // 3: interlaced, interrupt at half line zero so the end of field fires
        timing_sets[3] = '{10'd8, 10'd0, 10'd0, 12'd0, 12'd4095, 12'd0, 5'b00000};

        // fields: set, active, typed, line, field, frame, irq, duration
        // from reset every active line wraps at once and flips the field
        directed_rows[0]  = line_row(0, 1, 1, 0, 1, 1, 0, 1);
        directed_rows[1]  = line_row(0, 1, 1, 0, 0, 1, 1, 1);
        directed_rows[2]  = line_row(0, 0, 1, 0, 0, 0, 0, 'h800);
        directed_rows[3]  = line_row(0, 1, 1, 0, 1, 1, 0, 1);
        directed_rows[4]  = line_row(0, 0, 1, 0, 1, 0, 0, 'h800);
        // top values: leap line takes length b, normal line the widest duration
        directed_rows[5]  = line_row(1, 1, 1, 1, 1, 0, 0, 4095);
        directed_rows[6]  = line_row(1, 1, 1, 2, 1, 0, 0, 4096);
        directed_rows[7]  = line_row(1, 0, 1, 0, 1, 0, 0, 'h800);
        for (int i = 8; i < 14; i++)
            directed_rows[i] = line_row(2, 1, 0, 0, 0, 0, 0, 0);
        for (int i = 14; i < DIRECTED_ROWS; i++)
            directed_rows[i] = line_row(3, (i != 20), 0, 0, 0, 0, 0, 0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        gap_max = 3;
        cur_sel = 0;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].cfg_sel != cur_sel) begin
                settle();
                cur_sel = directed_rows[i].cfg_sel;
                load_timing(timing_sets[cur_sel], cur_sel == 1);
            end
            send_line(directed_rows[i].active, directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases: mostly short fields, two long ones that climb the
        // line counter through its low nine bits
        for (int phase = 0; phase < 10; phase++) begin
            bulk = (phase == 2 || phase == 7);
            hl = bulk ? $urandom_range(1000, 1023) : $urandom_range(0, 40);
            rnd.half_lines_per_field = 10'(hl);
            rnd.video_start_line     = 10'(bulk ? $urandom_range(0, 1023)
                                                : $urandom_range(0, hl + 2));
            rnd.interrupt_half_line  = 10'(($urandom_range(0, 4) == 0) ? 0 :
                                       (bulk ? $urandom_range(0, 1023)
                                             : $urandom_range(0, hl + 2)));
            rnd.quarter_line_length  = 12'($urandom_range(0, 4095));
            rnd.leap_length_a        = 12'($urandom_range(0, 4095));
            rnd.leap_length_b        = 12'($urandom_range(0, 4095));
            rnd.leap_pattern_bits    = 5'($urandom_range(0, 31));
            n_lines   = bulk ? 620 : $urandom_range(60, 90);
            idle_odds = bulk ? 1000 : 8;
            // some phases run with a steady valid
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = 0;

            settle();
            load_timing(rnd, 1'b0);
            for (int i = 0; i < n_lines; i++) begin
                // long phases stay active until the counter has had its full run
                active = (bulk && i < 560) || ($urandom_range(0, idle_odds - 1) != 0);
                send_line(active, 1'b0, '0);
            end
        end

        // drain and allow for the result stage
        s_tvalid <= 1'b0;
        while (line_expect.size() != 0 || line_notes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (errors == 0 && line_expect.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
